FILE: rtl/core/uvs_pkg.sv
// Shared types, widths and constants for the UV sphere vertex generator.
`timescale 1ns / 1ps
`default_nettype none
package uvs_pkg;

    localparam int CNT_W     = 11;   // ring/segment counts and indexes
    localparam int RAD_W     = 16;   // radius, unsigned Q8.8
    localparam int FRAC      = 30;   // Q30 angle and trig fractions
    localparam int MAG_W     = 31;   // Q30 magnitude, holds 1.0
    localparam int DEN_W     = 12;   // divisor width, holds 2 * rings
    localparam int DIV_NUM_W = 43;   // (4 * index) << 30
    localparam int TEX_W     = 17;   // Q0.16 with 1.0 representable
    localparam int POS_W     = 17;
    localparam int NORM_W    = 16;
    localparam int CFG_AW    = 2;
    localparam int CFG_DW    = 16;

    localparam int MAX_GRID_DEF = 1024;

    localparam logic [RAD_W-1:0] RADIUS_RST = 16'd256;
    localparam logic [CNT_W-1:0] RINGS_RST  = 11'd16;
    localparam logic [CNT_W-1:0] SEGS_RST   = 11'd32;

    localparam logic [MAG_W-1:0] ONE_Q30 = 31'h4000_0000;

    // Odd Taylor terms of sin(pi/2 * x), Q30, highest order first.
    localparam int HORNER_STEPS = 5;
    localparam logic [MAG_W-1:0] SIN_COEF [0:HORNER_STEPS] = '{
        31'd3864, 31'd172272, 31'd5026995, 31'd85569306,
        31'd693598668, 31'd1686629713
    };
    localparam int SIN_LAT = HORNER_STEPS + 2;

    typedef enum logic [CFG_AW-1:0] {
        CFG_RADIUS = 2'd0,
        CFG_RINGS  = 2'd1,
        CFG_SEGS   = 2'd2
    } t_cfg_reg;

    // Beat metadata that rides beside the trig pipeline.
    typedef struct packed {
        logic             clamped;
        logic [TEX_W-1:0] tex_u;
        logic [TEX_W-1:0] tex_v;
        logic [1:0]       quad_t;
        logic [1:0]       quad_p;
    } t_side;

endpackage
`default_nettype wire

FILE: rtl/core/uvs_div.sv
// Pipelined restoring divider, one quotient bit per stage.
`timescale 1ns / 1ps
`default_nettype none
module uvs_div #(
    parameter int NUM_W = uvs_pkg::DIV_NUM_W,
    parameter int DEN_W = uvs_pkg::DEN_W
) (
    input  wire              i_clk,
    input  wire              i_en,
    input  wire [NUM_W-1:0]  i_num,
    input  wire [DEN_W-1:0]  i_den,
    output logic [NUM_W-1:0] o_quo
);

    logic [DEN_W-1:0] r_rem [NUM_W];
    logic [NUM_W-1:0] r_nq  [NUM_W];
    logic [DEN_W-1:0] n_rem [NUM_W];
    logic [NUM_W-1:0] n_nq  [NUM_W];

    genvar k;
    generate
        for (k = 0; k < NUM_W; k++) begin : g_stage
            logic [DEN_W-1:0] w_rem_in;
            logic [NUM_W-1:0] w_nq_in;
            logic [DEN_W:0]   w_trial;
            logic [DEN_W:0]   w_diff;
            logic             w_ge;

            if (k == 0) begin : g_first
                assign w_rem_in = '0;
                assign w_nq_in  = i_num;
            end else begin : g_next
                assign w_rem_in = r_rem[k-1];
                assign w_nq_in  = r_nq[k-1];
            end

            // shift in the next numerator bit, subtract when it fits
            assign w_trial = {w_rem_in, w_nq_in[NUM_W-1]};
            assign w_diff  = w_trial - {1'b0, i_den};
            assign w_ge    = (w_trial >= {1'b0, i_den});
            assign n_rem[k] = w_ge ? w_diff[DEN_W-1:0] : w_trial[DEN_W-1:0];
            assign n_nq[k]  = {w_nq_in[NUM_W-2:0], w_ge};
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int s = 0; s < NUM_W; s++) begin
                r_rem[s] <= n_rem[s];
                r_nq[s]  <= n_nq[s];
            end
        end
    end

    assign o_quo = r_nq[NUM_W-1];

endmodule
`default_nettype wire

FILE: rtl/core/uvs_qsine.sv
// Pipelined quarter-wave sine, odd polynomial by Horner steps in Q30.
`timescale 1ns / 1ps
`default_nettype none
module uvs_qsine (
    input  wire                        i_clk,
    input  wire                        i_en,
    input  wire  [uvs_pkg::MAG_W-1:0]  i_x,
    output logic [uvs_pkg::MAG_W-1:0]  o_sin
);

    localparam int MW    = uvs_pkg::MAG_W;
    localparam int FR    = uvs_pkg::FRAC;
    localparam int STEPS = uvs_pkg::HORNER_STEPS;

    logic [MW-1:0]   r_x   [0:STEPS];
    logic [MW-1:0]   r_x2  [0:STEPS-1];
    logic [MW-1:0]   r_acc [0:STEPS];
    logic [MW-1:0]   n_acc [1:STEPS];
    logic [2*MW-1:0] w_prod [1:STEPS];
    logic [2*MW-1:0] w_sq;
    logic [2*MW-1:0] w_fin;
    logic [MW-1:0]   r_sin;

    assign w_sq  = (2*MW)'(i_x) * (2*MW)'(i_x);
    assign w_fin = (2*MW)'(r_x[STEPS]) * (2*MW)'(r_acc[STEPS]);

    genvar s;
    generate
        for (s = 1; s <= STEPS; s++) begin : g_horner
            assign w_prod[s] = (2*MW)'(r_x2[s-1]) * (2*MW)'(r_acc[s-1]);
            assign n_acc[s]  = uvs_pkg::SIN_COEF[s] - w_prod[s][FR+MW-1:FR];
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0]   <= i_x;
            r_x2[0]  <= w_sq[FR+MW-1:FR];
            r_acc[0] <= uvs_pkg::SIN_COEF[0];
            for (int k = 1; k <= STEPS; k++) begin
                r_x[k]   <= r_x[k-1];
                r_acc[k] <= n_acc[k];
            end
            for (int k = 1; k < STEPS; k++) begin
                r_x2[k] <= r_x2[k-1];
            end
            r_sin <= w_fin[FR+MW-1:FR];
        end
    end

    assign o_sin = r_sin;

endmodule
`default_nettype wire

FILE: rtl/core/uv_sphere_vertex_generator.sv
// Top level of the UV sphere vertex generator pipeline.
`timescale 1ns / 1ps
`default_nettype none
// UV sphere vertex generator.
// Input channel (i_valid / o_ready) carries one grid point per beat: a ring
// index and a segment index. Output channel (o_valid / i_ready) returns one
// vertex per beat: Q8.8 position, Q1.15 normal, Q0.16 texture coordinates and
// a flag that is set when either index was above its count and got clamped.
// Configuration: write radius, ring count and segment count through the
// plain write port while no beat is in flight; writes take effect at once.
// Pipeline: most of its depth is the 43-stage restoring divider that forms
// exact angle fractions, one quotient bit per stage; then 7 stages of
// polynomial sine, one stage of normal products, one of radius products and
// the output register.
// Throughput: one vertex per cycle. The whole pipe advances together; when
// the receiver holds i_ready low with a vertex waiting, every stage holds
// and o_ready drops, so nothing is lost or repeated.
// Reset (synchronous, active low) clears all valid bits and restores the
// registers to radius 1.0, 16 rings and 32 segments.
module uv_sphere_vertex_generator #(
    parameter int P_MAX_GRID = uvs_pkg::MAX_GRID_DEF
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_cfg_wr_en,
    input  wire  [uvs_pkg::CFG_AW-1:0]       i_cfg_addr,
    input  wire  [uvs_pkg::CFG_DW-1:0]       i_cfg_wdata,
    input  wire                              i_valid,
    output logic                             o_ready,
    input  wire  [uvs_pkg::CNT_W-1:0]        i_ring_index,
    input  wire  [uvs_pkg::CNT_W-1:0]        i_segment_index,
    output logic                             o_valid,
    input  wire                              i_ready,
    output logic signed [uvs_pkg::POS_W-1:0]  o_pos_x,
    output logic signed [uvs_pkg::POS_W-1:0]  o_pos_y,
    output logic signed [uvs_pkg::POS_W-1:0]  o_pos_z,
    output logic signed [uvs_pkg::NORM_W-1:0] o_norm_x,
    output logic signed [uvs_pkg::NORM_W-1:0] o_norm_y,
    output logic signed [uvs_pkg::NORM_W-1:0] o_norm_z,
    output logic [uvs_pkg::TEX_W-1:0]        o_tex_u,
    output logic [uvs_pkg::TEX_W-1:0]        o_tex_v,
    output logic                             o_index_clamped
);

    localparam int CW    = uvs_pkg::CNT_W;
    localparam int MW    = uvs_pkg::MAG_W;
    localparam int FR    = uvs_pkg::FRAC;
    localparam int RW    = uvs_pkg::RAD_W;
    localparam int NW    = uvs_pkg::DIV_NUM_W;
    localparam int DW    = uvs_pkg::DEN_W;
    localparam int TW    = uvs_pkg::TEX_W;
    localparam int PW    = uvs_pkg::POS_W;
    localparam int QW    = uvs_pkg::NORM_W;
    localparam int SLAT  = uvs_pkg::SIN_LAT;
    localparam int PRW   = MW + RW;               // radius product width
    localparam int DEPTH = 1 + NW + SLAT + 3;     // front, divider, sine, M, P, out

    // ---------------- configuration registers ----------------
    logic [RW-1:0] r_radius;
    logic [CW-1:0] r_ring_cnt;
    logic [CW-1:0] r_seg_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius   <= uvs_pkg::RADIUS_RST;
            r_ring_cnt <= uvs_pkg::RINGS_RST;
            r_seg_cnt  <= uvs_pkg::SEGS_RST;
        end else if (i_cfg_wr_en) begin
            unique case (uvs_pkg::t_cfg_reg'(i_cfg_addr))
                uvs_pkg::CFG_RADIUS: r_radius   <= i_cfg_wdata[RW-1:0];
                uvs_pkg::CFG_RINGS:  r_ring_cnt <= i_cfg_wdata[CW-1:0];
                uvs_pkg::CFG_SEGS:   r_seg_cnt  <= i_cfg_wdata[CW-1:0];
                default: ;      // drop writes to unknown registers
            endcase
        end
    end

    // Effective counts: zero acts as one, above the grid limit acts as the limit.
    function automatic logic [CW-1:0] eff_count(input logic [CW-1:0] c);
        logic [CW-1:0] res;
        res = c;
        if (c == '0) begin
            res = CW'(1);
        end else if (32'(c) > P_MAX_GRID) begin
            res = CW'(P_MAX_GRID);
        end
        return res;
    endfunction

    logic [CW-1:0] w_rings;
    logic [CW-1:0] w_segs;
    assign w_rings = eff_count(r_ring_cnt);
    assign w_segs  = eff_count(r_seg_cnt);

    // ---------------- pipeline control ----------------
    logic             w_adv;
    logic             w_acc;
    logic [DEPTH-1:0] r_vld;

    assign w_adv   = !r_vld[DEPTH-1] || i_ready;
    assign o_ready = w_adv;
    assign w_acc   = i_valid && w_adv;
    assign o_valid = r_vld[DEPTH-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_adv) begin
            r_vld <= {r_vld[DEPTH-2:0], w_acc};
        end
    end

    // ---------------- front stage: clamp indexes ----------------
    logic [CW-1:0] r_ring_f;
    logic [CW-1:0] r_seg_f;
    logic          r_clp_f;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_ring_f <= (i_ring_index > w_rings) ? w_rings : i_ring_index;
            r_seg_f  <= (i_segment_index > w_segs) ? w_segs : i_segment_index;
            r_clp_f  <= (i_ring_index > w_rings) || (i_segment_index > w_segs);
        end
    end

    // ---------------- exact division stage ----------------
    logic [NW-1:0] w_num_t, w_num_p, w_num_u, w_num_v;
    logic [DW-1:0] w_den_t, w_den_p;
    logic [NW-1:0] w_quo_t, w_quo_p, w_quo_u, w_quo_v;

    // four times the fraction of a turn, scaled by 2^30
    assign w_num_t = {r_ring_f, 2'b00, {FR{1'b0}}};
    assign w_num_p = {r_seg_f, 2'b00, {FR{1'b0}}};
    assign w_den_t = {w_rings, 1'b0};
    assign w_den_p = {1'b0, w_segs};
    // rounded texture coordinates: (i * 65536 + n / 2) / n
    assign w_num_u = NW'({r_seg_f, 16'b0}) + NW'(w_segs >> 1);
    assign w_num_v = NW'({r_ring_f, 16'b0}) + NW'(w_rings >> 1);

    uvs_div #(.NUM_W(NW), .DEN_W(DW)) u_div_t (
        .i_clk(i_clk), .i_en(w_adv), .i_num(w_num_t), .i_den(w_den_t), .o_quo(w_quo_t)
    );
    uvs_div #(.NUM_W(NW), .DEN_W(DW)) u_div_p (
        .i_clk(i_clk), .i_en(w_adv), .i_num(w_num_p), .i_den(w_den_p), .o_quo(w_quo_p)
    );
    uvs_div #(.NUM_W(NW), .DEN_W(DW)) u_div_u (
        .i_clk(i_clk), .i_en(w_adv), .i_num(w_num_u), .i_den(w_den_p), .o_quo(w_quo_u)
    );
    uvs_div #(.NUM_W(NW), .DEN_W(DW)) u_div_v (
        .i_clk(i_clk), .i_en(w_adv), .i_num(w_num_v), .i_den({1'b0, w_rings}),
        .o_quo(w_quo_v)
    );

    // carry the clamp flag beside the divider
    logic [NW-1:0] r_clp_d;
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_clp_d <= {r_clp_d[NW-2:0], r_clp_f};
        end
    end

    // ---------------- sine stage ----------------
    logic [MW-1:0] w_ft, w_fp;
    logic [MW-1:0] w_a_t, w_b_t, w_a_p, w_b_p;
    uvs_pkg::t_side w_side;
    uvs_pkg::t_side r_side [SLAT];

    assign w_ft = {1'b0, w_quo_t[FR-1:0]};
    assign w_fp = {1'b0, w_quo_p[FR-1:0]};

    always_comb begin
        w_side.clamped = r_clp_d[NW-1];
        w_side.tex_u   = w_quo_u[TW-1:0];
        w_side.tex_v   = TW'(uvs_pkg::ONE_Q30 >> 14) - w_quo_v[TW-1:0];
        w_side.quad_t  = w_quo_t[FR+1:FR];
        w_side.quad_p  = w_quo_p[FR+1:FR];
    end

    uvs_qsine u_sin_at (.i_clk(i_clk), .i_en(w_adv), .i_x(w_ft), .o_sin(w_a_t));
    uvs_qsine u_sin_bt (.i_clk(i_clk), .i_en(w_adv), .i_x(uvs_pkg::ONE_Q30 - w_ft),
                        .o_sin(w_b_t));
    uvs_qsine u_sin_ap (.i_clk(i_clk), .i_en(w_adv), .i_x(w_fp), .o_sin(w_a_p));
    uvs_qsine u_sin_bp (.i_clk(i_clk), .i_en(w_adv), .i_x(uvs_pkg::ONE_Q30 - w_fp),
                        .o_sin(w_b_p));

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_side[0] <= w_side;
            for (int k = 1; k < SLAT; k++) begin
                r_side[k] <= r_side[k-1];
            end
        end
    end

    // ---------------- normal product stage ----------------
    // odd quadrants swap sine and cosine; signs follow the quadrant
    logic [MW-1:0]   w_st, w_ct, w_sp, w_cp;
    logic            w_stn, w_ctn, w_spn, w_cpn;
    logic [2*MW:0]   w_nx_full, w_nz_full;
    uvs_pkg::t_side  w_sd;

    assign w_sd  = r_side[SLAT-1];
    assign w_st  = w_sd.quad_t[0] ? w_b_t : w_a_t;
    assign w_ct  = w_sd.quad_t[0] ? w_a_t : w_b_t;
    assign w_stn = w_sd.quad_t[1];
    assign w_ctn = w_sd.quad_t[1] ^ w_sd.quad_t[0];
    assign w_sp  = w_sd.quad_p[0] ? w_b_p : w_a_p;
    assign w_cp  = w_sd.quad_p[0] ? w_a_p : w_b_p;
    assign w_spn = w_sd.quad_p[1];
    assign w_cpn = w_sd.quad_p[1] ^ w_sd.quad_p[0];

    assign w_nx_full = (2*MW+1)'(w_cp) * (2*MW+1)'(w_st) + (2*MW+1)'(1 << (FR-1));
    assign w_nz_full = (2*MW+1)'(w_sp) * (2*MW+1)'(w_st) + (2*MW+1)'(1 << (FR-1));

    logic [MW-1:0]  r_nx_m, r_ny_m, r_nz_m;
    logic           r_nxn_m, r_nyn_m, r_nzn_m;
    uvs_pkg::t_side r_side_m;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_nx_m   <= w_nx_full[FR+MW-1:FR];
            r_nz_m   <= w_nz_full[FR+MW-1:FR];
            r_ny_m   <= w_ct;
            r_nxn_m  <= w_cpn ^ w_stn;
            r_nzn_m  <= w_spn ^ w_stn;
            r_nyn_m  <= w_ctn;
            r_side_m <= w_sd;
        end
    end

    // ---------------- radius product stage ----------------
    logic [PRW-1:0] r_px_p, r_py_p, r_pz_p;
    logic [MW-1:0]  r_nx_p, r_ny_p, r_nz_p;
    logic           r_nxn_p, r_nyn_p, r_nzn_p;
    uvs_pkg::t_side r_side_p;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_px_p   <= PRW'(r_nx_m) * PRW'(r_radius);
            r_py_p   <= PRW'(r_ny_m) * PRW'(r_radius);
            r_pz_p   <= PRW'(r_nz_m) * PRW'(r_radius);
            r_nx_p   <= r_nx_m;
            r_ny_p   <= r_ny_m;
            r_nz_p   <= r_nz_m;
            r_nxn_p  <= r_nxn_m;
            r_nyn_p  <= r_nyn_m;
            r_nzn_p  <= r_nzn_m;
            r_side_p <= r_side_m;
        end
    end

    // ---------------- output stage: round, saturate, apply sign ----------------
    function automatic logic [PW-1:0] pos_field(input logic [PRW-1:0] prod, input logic neg);
        logic [PRW:0]  sum;
        logic [PW:0]   v;
        logic [PW-1:0] m;
        sum = {1'b0, prod} + (PRW+1)'(1 << (FR-1));
        v   = sum[FR+PW:FR];
        m   = (v > (PW+1)'(65535)) ? PW'(65535) : v[PW-1:0];
        return neg ? PW'(-m) : m;
    endfunction

    function automatic logic [QW-1:0] norm_field(input logic [MW-1:0] mag, input logic neg);
        logic [MW:0]   sum;
        logic [QW:0]   v;
        logic [QW:0]   m;
        sum = {1'b0, mag} + (MW+1)'(1 << 14);
        v   = sum[15+QW:15];
        if (neg) begin
            m = (v > (QW+1)'(32768)) ? (QW+1)'(32768) : v;
            return QW'(-m);
        end
        m = (v > (QW+1)'(32767)) ? (QW+1)'(32767) : v;
        return m[QW-1:0];
    endfunction

    logic [PW-1:0] r_pos_x, r_pos_y, r_pos_z;
    logic [QW-1:0] r_norm_x, r_norm_y, r_norm_z;
    logic [TW-1:0] r_tex_u, r_tex_v;
    logic          r_clamped;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_pos_x   <= pos_field(r_px_p, r_nxn_p);
            r_pos_y   <= pos_field(r_py_p, r_nyn_p);
            r_pos_z   <= pos_field(r_pz_p, r_nzn_p);
            r_norm_x  <= norm_field(r_nx_p, r_nxn_p);
            r_norm_y  <= norm_field(r_ny_p, r_nyn_p);
            r_norm_z  <= norm_field(r_nz_p, r_nzn_p);
            r_tex_u   <= r_side_p.tex_u;
            r_tex_v   <= r_side_p.tex_v;
            r_clamped <= r_side_p.clamped;
        end
    end

    assign o_pos_x         = r_pos_x;
    assign o_pos_y         = r_pos_y;
    assign o_pos_z         = r_pos_z;
    assign o_norm_x        = r_norm_x;
    assign o_norm_y        = r_norm_y;
    assign o_norm_z        = r_norm_z;
    assign o_tex_u         = r_tex_u;
    assign o_tex_v         = r_tex_v;
    assign o_index_clamped = r_clamped;

`ifndef SYNTH
    // upper hemisphere (v at least one half) never has a negative y normal
    a_north_y: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_tex_v >= TW'(32768))) |-> !o_norm_y[QW-1])
        else $error("negative y normal in upper hemisphere");

    // on the seam (u of zero or one) the z components vanish
    a_seam_z: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && ((o_tex_u == '0) || (o_tex_u == TW'(65536))))
        |-> ((o_norm_z == '0) && (o_pos_z == '0)))
        else $error("nonzero z on the seam");

    // a negative x position needs a normal x that is not positive
    a_sign_x: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_pos_x[PW-1]) |-> (o_norm_x[QW-1] || (o_norm_x == '0)))
        else $error("position and normal x disagree in sign");

    // a waiting vertex holds while the receiver stalls
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_tex_u) && $stable(o_pos_y)))
        else $error("stalled vertex changed");
`endif

endmodule
`default_nettype wire

FILE: dv/tb_uv_sphere_vertex_generator.sv
// Self-checking testbench for the UV sphere vertex generator.
`timescale 1ns / 1ps
`default_nettype none
module tb_uv_sphere_vertex_generator;

    // Vertex as seen on the output channel.
    typedef struct packed {
        logic signed [uvs_pkg::POS_W-1:0]  pos_x;
        logic signed [uvs_pkg::POS_W-1:0]  pos_y;
        logic signed [uvs_pkg::POS_W-1:0]  pos_z;
        logic signed [uvs_pkg::NORM_W-1:0] norm_x;
        logic signed [uvs_pkg::NORM_W-1:0] norm_y;
        logic signed [uvs_pkg::NORM_W-1:0] norm_z;
        logic [uvs_pkg::TEX_W-1:0]         tex_u;
        logic [uvs_pkg::TEX_W-1:0]         tex_v;
        logic                              clamped;
    } t_vertex;

    typedef struct packed {
        logic [uvs_pkg::CNT_W-1:0] ring;
        logic [uvs_pkg::CNT_W-1:0] seg;
    } t_grid_pt;

    localparam int PIPE_LAT  = 54;
    localparam int STALL_LIM = 4000;

    logic                              i_clk = 1'b0;
    logic                              i_rst_n = 1'b0;
    logic                              i_cfg_wr_en = 1'b0;
    logic [uvs_pkg::CFG_AW-1:0]        i_cfg_addr = '0;
    logic [uvs_pkg::CFG_DW-1:0]        i_cfg_wdata = '0;
    logic                              i_valid = 1'b0;
    logic                              o_ready;
    logic [uvs_pkg::CNT_W-1:0]         i_ring_index = '0;
    logic [uvs_pkg::CNT_W-1:0]         i_segment_index = '0;
    logic                              o_valid;
    logic                              i_ready = 1'b0;
    logic signed [uvs_pkg::POS_W-1:0]  o_pos_x, o_pos_y, o_pos_z;
    logic signed [uvs_pkg::NORM_W-1:0] o_norm_x, o_norm_y, o_norm_z;
    logic [uvs_pkg::TEX_W-1:0]         o_tex_u, o_tex_v;
    logic                              o_index_clamped;

    uv_sphere_vertex_generator i_dut (.*);

    always #1 i_clk = ~i_clk;

    // Shadow copy of the configuration registers.
    logic [uvs_pkg::RAD_W-1:0] radius_q = uvs_pkg::RADIUS_RST;
    logic [uvs_pkg::CNT_W-1:0] rings_q  = uvs_pkg::RINGS_RST;
    logic [uvs_pkg::CNT_W-1:0] segs_q   = uvs_pkg::SEGS_RST;

    t_grid_pt pending_pts[$];
    t_vertex  expected_verts[$];
    int       mismatch_cnt = 0;
    int       idle_cnt = 0;
    bit       timed_out = 1'b0;
    bit       no_idle = 1'b0;     // long stretch with no random gaps
    int       hold_off = 0;       // receiver back-pressure cycles left

    // sin(pi/2 * x) in Q30, odd polynomial with truncating Horner steps.
    function automatic logic [63:0] qsine(input logic [63:0] x);
        logic [63:0] x2, r;
        x2 = (x * x) >> 30;
        r  = 64'd3864;
        r  = 64'd172272     - ((x2 * r) >> 30);
        r  = 64'd5026995    - ((x2 * r) >> 30);
        r  = 64'd85569306   - ((x2 * r) >> 30);
        r  = 64'd693598668  - ((x2 * r) >> 30);
        r  = 64'd1686629713 - ((x2 * r) >> 30);
        return (x * r) >> 30;
    endfunction

    // Sine and cosine of num/den turn as magnitude plus sign.
    task automatic turn_sincos(input logic [63:0] num, input logic [63:0] den,
                               output logic [63:0] sm, output bit sn,
                               output logic [63:0] cm, output bit cn);
        logic [63:0] t, f, a, b;
        logic [1:0]  q;
        t = 4 * num;
        q = 2'((t / den) & 3);
        f = ((t % den) << 30) / den;
        a = qsine(f);
        b = qsine(64'd1073741824 - f);
        case (q)
            2'd0: begin sm = a; sn = 0; cm = b; cn = 0; end
            2'd1: begin sm = b; sn = 0; cm = a; cn = 1; end
            2'd2: begin sm = a; sn = 1; cm = b; cn = 1; end
            default: begin sm = b; sn = 1; cm = a; cn = 0; end
        endcase
    endtask

    function automatic logic [63:0] sat_field(input logic [63:0] mag, input bit neg,
                                              input logic [63:0] maxp,
                                              input logic [63:0] maxn);
        if (neg) return 64'd0 - ((mag > maxn) ? maxn : mag);
        return (mag > maxp) ? maxp : mag;
    endfunction

    function automatic logic [uvs_pkg::NORM_W-1:0] norm_fix(input logic [63:0] m,
                                                            input bit n);
        return uvs_pkg::NORM_W'(sat_field((m + 16384) >> 15, n, 32767, 32768));
    endfunction

    function automatic logic [uvs_pkg::POS_W-1:0] pos_fix(input logic [63:0] m,
                                                          input bit n);
        return uvs_pkg::POS_W'(sat_field((m * radius_q + (64'd1 << 29)) >> 30, n,
                                         65535, 65535));
    endfunction

    function automatic logic [63:0] grid_count(input logic [uvs_pkg::CNT_W-1:0] c);
        if (c == 0) return 1;
        if (c > uvs_pkg::MAX_GRID_DEF) return uvs_pkg::MAX_GRID_DEF;
        return c;
    endfunction

    // Expected vertex for one grid point under the current registers.
    task automatic predict_vertex(input t_grid_pt p, output t_vertex v);
        logic [63:0] rings, segs, ring, seg, st, ct, sp, cp, nx, nz, uq, vq;
        bit stn, ctn, spn, cpn;
        rings = grid_count(rings_q);
        segs  = grid_count(segs_q);
        ring  = p.ring;
        seg   = p.seg;
        v.clamped = 1'b0;
        if (ring > rings) begin ring = rings; v.clamped = 1'b1; end
        if (seg > segs) begin seg = segs; v.clamped = 1'b1; end
        turn_sincos(ring, 2 * rings, st, stn, ct, ctn);
        turn_sincos(seg, segs, sp, spn, cp, cpn);
        nx = (cp * st + (64'd1 << 29)) >> 30;
        nz = (sp * st + (64'd1 << 29)) >> 30;
        uq = (seg * 65536 + segs / 2) / segs;
        vq = (ring * 65536 + rings / 2) / rings;
        v.pos_x  = pos_fix(nx, cpn != stn);
        v.pos_y  = pos_fix(ct, ctn);
        v.pos_z  = pos_fix(nz, spn != stn);
        v.norm_x = norm_fix(nx, cpn != stn);
        v.norm_y = norm_fix(ct, ctn);
        v.norm_z = norm_fix(nz, spn != stn);
        v.tex_u  = uvs_pkg::TEX_W'(uq);
        v.tex_v  = uvs_pkg::TEX_W'(65536 - vq);
    endtask

    // Driver: offer queued grid points, hold until the beat is taken.
    always @(posedge i_clk) begin
        t_vertex v;
        if (i_rst_n) begin
            if (i_valid && o_ready) begin
                predict_vertex({i_ring_index, i_segment_index}, v);
                expected_verts.insert(expected_verts.size(), v);
            end
            if (!i_valid || o_ready) begin
                if (pending_pts.size() > 0 && (no_idle || $urandom_range(99) >= 7)) begin
                    t_grid_pt p;
                    p = pending_pts.pop_front();
                    i_valid         <= 1'b1;
                    i_ring_index    <= p.ring;
                    i_segment_index <= p.seg;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver ready: random stalls plus a long hold-off when requested.
    always @(posedge i_clk) begin
        if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            i_ready  <= 1'b0;
        end else begin
            i_ready <= no_idle || ($urandom_range(99) >= 7);
        end
    end

    // Monitor: compare each vertex beat with the oldest expectation.
    always @(posedge i_clk) begin
        t_vertex got, exp_v;
        if (i_rst_n && o_valid && i_ready) begin
            got = {o_pos_x, o_pos_y, o_pos_z, o_norm_x, o_norm_y, o_norm_z,
                   o_tex_u, o_tex_v, o_index_clamped};
            if (expected_verts.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= 10) $display("ERROR: unexpected vertex %p", got);
            end else begin
                exp_v = expected_verts.pop_front();
                if (got !== exp_v) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display("ERROR: vertex mismatch\n  exp %p\n  got %p", exp_v, got);
                end
            end
        end
    end

    // Watchdog: count cycles with no beat on either channel.
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) idle_cnt <= 0;
        else idle_cnt <= idle_cnt + 1;
        if (idle_cnt == STALL_LIM && !timed_out) begin
            timed_out = 1'b1;
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic write_reg(input uvs_pkg::t_cfg_reg idx,
                             input logic [uvs_pkg::CFG_DW-1:0] val);
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        case (idx)
            uvs_pkg::CFG_RADIUS: radius_q = val;
            uvs_pkg::CFG_RINGS:  rings_q  = val[uvs_pkg::CNT_W-1:0];
            default:             segs_q   = val[uvs_pkg::CNT_W-1:0];
        endcase
    endtask

    // Append one grid point to the pending queue.
    task automatic queue_pt(input logic [uvs_pkg::CNT_W-1:0] r,
                            input logic [uvs_pkg::CNT_W-1:0] s);
        t_grid_pt p;
        p.ring = r;
        p.seg  = s;
        pending_pts.insert(pending_pts.size(), p);
    endtask

    // Wait until every queued point is sent and every vertex is back.
    // Sample between edges so the driver's updates have settled.
    task automatic drain;
        @(negedge i_clk);
        while (pending_pts.size() > 0 || i_valid || expected_verts.size() > 0)
            @(negedge i_clk);
        repeat (PIPE_LAT + 4) @(posedge i_clk);
    endtask

    // Mostly in-range points, some beyond the count to hit clamping.
    task automatic queue_random(input int n);
        t_grid_pt p;
        int rc, sc;
        rc = int'(grid_count(rings_q));
        sc = int'(grid_count(segs_q));
        repeat (n) begin
            if ($urandom_range(9) == 0) begin
                p.ring = uvs_pkg::CNT_W'($urandom);
                p.seg  = uvs_pkg::CNT_W'($urandom);
            end else begin
                p.ring = uvs_pkg::CNT_W'($urandom_range(rc));
                p.seg  = uvs_pkg::CNT_W'($urandom_range(sc));
            end
            pending_pts.insert(pending_pts.size(), p);
        end
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: poles, equator, quadrant edges, clamping, field extremes.
        queue_pt(11'd0, 11'd0);
        queue_pt(11'd16, 11'd32);
        queue_pt(11'd8, 11'd8);
        queue_pt(11'd8, 11'd16);
        queue_pt(11'd8, 11'd24);
        queue_pt(11'd4, 11'd4);
        queue_pt(11'd12, 11'd20);
        queue_pt(11'd17, 11'd3);
        queue_pt(11'd5, 11'd33);
        queue_pt(11'h7FF, 11'h7FF);
        queue_pt(11'h555, 11'h2AA);
        queue_pt(11'h2AA, 11'h555);
        drain();

        // Large radius saturates positions; zero counts act as one.
        write_reg(uvs_pkg::CFG_RADIUS, 16'hFFFF);
        write_reg(uvs_pkg::CFG_RINGS, 16'd0);
        write_reg(uvs_pkg::CFG_SEGS, 16'd0);
        queue_pt(11'd0, 11'd0);
        queue_pt(11'd1, 11'd1);
        queue_pt(11'd2, 11'd0);
        queue_pt(11'd1, 11'd0);
        drain();

        // Counts above the grid limit clamp to it; all-ones register bits.
        write_reg(uvs_pkg::CFG_RADIUS, 16'd0);
        write_reg(uvs_pkg::CFG_RINGS, 16'h07FF);
        write_reg(uvs_pkg::CFG_SEGS, 16'h07FF);
        queue_pt(11'd512, 11'd256);
        queue_pt(11'd1024, 11'd1024);
        queue_pt(11'd1025, 11'd1);
        drain();

        // Random phases across settings; one phase with full back-pressure.
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: begin write_reg(uvs_pkg::CFG_RADIUS, 16'd256);
                         write_reg(uvs_pkg::CFG_RINGS, 16'd1);
                         write_reg(uvs_pkg::CFG_SEGS, 16'd1); end
                1: begin write_reg(uvs_pkg::CFG_RADIUS, 16'hFFFF);
                         write_reg(uvs_pkg::CFG_RINGS, 16'd1024);
                         write_reg(uvs_pkg::CFG_SEGS, 16'd1024); end
                default: begin
                    write_reg(uvs_pkg::CFG_RADIUS, 16'($urandom));
                    write_reg(uvs_pkg::CFG_RINGS, 16'($urandom_range(1, 300)));
                    write_reg(uvs_pkg::CFG_SEGS, 16'($urandom_range(1, 300)));
                end
            endcase
            no_idle = (ph == 3);
            if (ph == 2) hold_off = 300;
            queue_random(105);
            drain();
        end

        if (mismatch_cnt == 0 && expected_verts.size() == 0) $display("TEST PASSED");
        else $display("TEST FAILED");
        $finish;
    end
endmodule
`default_nettype wire
